### sv/psh_pkg.sv
// Package for the per-segment stacked histogram.
// Sizes, function and status codes, register indexes and the queue item type.
// No dependencies.
package psh_pkg;

	localparam int MAX_BINS     = 256;
	localparam int MAX_SEGMENTS = 16;
	localparam int SAMPLE_BITS  = 16;

	localparam int SEG_W  = 4;
	localparam int BIN_W  = 8;
	localparam int NB_W   = 9;
	localparam int SC_W   = 5;
	localparam int DEN_W  = SAMPLE_BITS;
	localparam int NUM_W  = DEN_W + NB_W;
	localparam int ADDR_W = SEG_W + BIN_W;
	localparam int CNT_W  = 32;
	localparam int QK_W   = 4;

	localparam logic [1:0] FN_COUNT = 2'd0;
	localparam logic [1:0] FN_READ  = 2'd1;
	localparam logic [1:0] FN_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_SEG = 2'd1;
	localparam logic [1:0] ST_BAD_BIN = 2'd2;

	localparam logic [1:0] REG_MIN  = 2'd0;
	localparam logic [1:0] REG_MAX  = 2'd1;
	localparam logic [1:0] REG_BINS = 2'd2;
	localparam logic [1:0] REG_SEGS = 2'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [1:0]       status;
		logic [SEG_W-1:0] seg;
		logic [BIN_W-1:0] bin;
		logic             need_div;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} item_t;

endpackage

### sv/psh_front.sv
// Front end of the histogram: configuration registers and item classification.
// Depends on psh_pkg.
module psh_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [1:0]                wr_index,
	input  logic [15:0]               wr_data,
	input  logic [1:0]                func,
	input  logic signed [15:0]        sample_value,
	input  logic [psh_pkg::SEG_W-1:0] segment_id,
	input  logic [psh_pkg::BIN_W-1:0] read_bin,
	output psh_pkg::item_t            item
);
	import psh_pkg::*;

	logic signed [15:0] range_min_q, range_max_q;
	logic [NB_W-1:0]    bin_count_q;
	logic [SC_W-1:0]    seg_count_q;
	logic [NB_W-1:0]    nb;
	logic               seg_ok;
	logic signed [16:0] diff_v, diff_r;
	logic [NB_W-1:0]    nb_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= 16'sd0;
			range_max_q <= 16'sd32767;
			bin_count_q <= 9'd64;
			seg_count_q <= 5'd16;
		end else if (wr_en) begin
			case (wr_index)
				REG_MIN:  range_min_q <= wr_data;
				REG_MAX:  range_max_q <= wr_data;
				REG_BINS: bin_count_q <= wr_data[NB_W-1:0];
				REG_SEGS: seg_count_q <= wr_data[SC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (bin_count_q == '0)
			nb = 9'd1;
		else if (bin_count_q > 9'(MAX_BINS))
			nb = 9'(MAX_BINS);
		else
			nb = bin_count_q;
		nb_m1  = nb - 9'd1;
		seg_ok = {1'b0, segment_id} < seg_count_q;
		diff_v = 17'(sample_value) - 17'(range_min_q);
		diff_r = 17'(range_max_q) - 17'(range_min_q);

		item          = '0;
		item.seg      = segment_id;
		item.den      = diff_r[15:0];
		item.num      = NUM_W'(diff_v[15:0]) * NUM_W'(nb);
		if (func == FN_COUNT) begin
			item.kind = FN_COUNT;
			if (range_max_q <= range_min_q || sample_value <= range_min_q)
				item.bin = '0;
			else if (sample_value >= range_max_q)
				item.bin = nb_m1[BIN_W-1:0];
			else
				item.need_div = 1'b1;
			item.status = seg_ok ? ST_OK : ST_BAD_SEG;
		end else begin
			item.kind = (func == FN_CLEAR) ? FN_CLEAR : FN_READ;
			item.bin  = read_bin;
			if (!seg_ok)
				item.status = ST_BAD_SEG;
			else if ({1'b0, read_bin} >= nb)
				item.status = ST_BAD_BIN;
			else
				item.status = ST_OK;
		end
	end
endmodule

### sv/psh_fifo.sv
// Two-entry queue of classified items between front and back ends.
// Depends on psh_pkg.
module psh_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  psh_pkg::item_t wdata,
	input  logic           rd,
	output psh_pkg::item_t rdata,
	output logic           full,
	output logic           empty
);
	import psh_pkg::*;

	item_t      ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			ent_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr)
				wp_q <= ~wp_q;
			if (rd)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule

### sv/psh_back.sv
// Back end: bin divider, count memory read-modify-write, result register.
// Also runs the clearing pass over the count memory after reset. Depends on psh_pkg.
module psh_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  psh_pkg::item_t            qdata,
	input  logic                      qempty,
	output logic                      qpop,
	output logic                      clearing,
	input  logic                      pop,
	output logic                      empty,
	output logic [psh_pkg::BIN_W-1:0] bin_index,
	output logic [psh_pkg::CNT_W-1:0] count_value,
	output logic [1:0]                status
);
	import psh_pkg::*;

	typedef enum logic [2:0] {S_CLR, S_IDLE, S_DIV, S_RD, S_UPD} state_t;

	localparam int DEPTH = MAX_SEGMENTS * MAX_BINS;

	state_t            state_q;
	item_t             it_q;
	logic [NUM_W-1:0]  rem_q;
	logic [QK_W-1:0]   k_q;
	logic [NB_W-1:0]   quo_q;
	logic [ADDR_W-1:0] clr_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  mem [DEPTH];
	logic [CNT_W-1:0]  rd_data_q;
	logic [ADDR_W-1:0] addr;
	logic [NUM_W-1:0]  den_sh;
	logic              out_free, upd_go, mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [CNT_W-1:0]  mem_wd, new_cnt;

	assign clearing = state_q == S_CLR;
	assign qpop     = state_q == S_IDLE && !qempty;
	assign empty    = !out_valid_q;
	assign out_free = !out_valid_q || pop;
	assign addr     = {it_q.seg, quo_q[BIN_W-1:0]};
	assign den_sh   = NUM_W'({{NB_W{1'b0}}, it_q.den} << k_q);
	assign upd_go   = state_q == S_UPD && out_free;

	always_comb begin
		case (it_q.kind)
			FN_COUNT: new_cnt = (rd_data_q == '1) ? rd_data_q : rd_data_q + 32'd1;
			default:  new_cnt = '0;
		endcase
		if (clearing) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else begin
			mem_we = upd_go && it_q.status == ST_OK && it_q.kind != FN_READ;
			mem_wa = addr;
			mem_wd = new_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_data_q <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (qpop)
			it_q <= qdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			rem_q       <= '0;
			k_q         <= '0;
			quo_q       <= '0;
			out_valid_q <= 1'b0;
			bin_index   <= '0;
			count_value <= '0;
			status      <= ST_OK;
		end else begin
			if (upd_go)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (upd_go) begin
				bin_index <= quo_q[BIN_W-1:0];
				status    <= it_q.status;
				if (it_q.status != ST_OK)
					count_value <= '0;
				else if (it_q.kind == FN_COUNT)
					count_value <= new_cnt;
				else
					count_value <= rd_data_q;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (!qempty) begin
						rem_q <= qdata.num;
						k_q   <= QK_W'(NB_W - 1);
						quo_q <= {1'b0, qdata.bin};
						state_q <= qdata.need_div ? S_DIV : S_RD;
					end
				end
				S_DIV: begin
					if (rem_q >= den_sh) begin
						rem_q        <= rem_q - den_sh;
						quo_q[k_q]   <= 1'b1;
					end else
						quo_q[k_q]   <= 1'b0;
					k_q <= k_q - 1'b1;
					if (k_q == '0)
						state_q <= S_RD;
				end
				S_RD: state_q <= S_UPD;
				S_UPD: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### sv/per_segment_stacked_histogram.sv
// Top level of the per-segment stacked histogram.
// Depends on psh_pkg, psh_front, psh_fifo, psh_back.
//
//   channel   handshake          payload
//   input     push / full        func, sample_value, segment_id, read_bin
//   result    empty / pop        bin_index, count_value, status
//   config    wr_en              wr_index, wr_data
//
// A count transaction in the back end passes through a 9-step restoring divider,
// memory read and update; reads, clears and no-division bins skip the divider.
// After reset a clearing pass writes all 4096 counts while holding full high.
// The two-entry queue and the result register let input and output stall apart.
module per_segment_stacked_histogram (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [1:0]                wr_index,
	input  logic [15:0]               wr_data,
	input  logic                      push,
	output logic                      full,
	input  logic [1:0]                func,
	input  logic signed [15:0]        sample_value,
	input  logic [psh_pkg::SEG_W-1:0] segment_id,
	input  logic [psh_pkg::BIN_W-1:0] read_bin,
	output logic                      empty,
	input  logic                      pop,
	output logic [psh_pkg::BIN_W-1:0] bin_index,
	output logic [psh_pkg::CNT_W-1:0] count_value,
	output logic [1:0]                status
);
	import psh_pkg::*;

	item_t f_item, q_item;
	logic  q_full, q_empty, q_pop, clearing;

	assign full = q_full || clearing;

	psh_front u_front (
		.clk, .arst_n, .wr_en, .wr_index, .wr_data,
		.func, .sample_value, .segment_id, .read_bin,
		.item (f_item)
	);

	psh_fifo u_fifo (
		.clk, .arst_n,
		.wr    (push && !full),
		.wdata (f_item),
		.rd    (q_pop),
		.rdata (q_item),
		.full  (q_full),
		.empty (q_empty)
	);

	psh_back u_back (
		.clk, .arst_n,
		.qdata (q_item),
		.qempty (q_empty),
		.qpop  (q_pop),
		.clearing,
		.pop, .empty, .bin_index, .count_value, .status
	);
endmodule
